/* rtl/group_order_reverser_macros.svh */
// Assertion macros used by the group order reverser RTL
`ifndef GROUP_ORDER_REVERSER_MACROS_SVH
`define GROUP_ORDER_REVERSER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define GOR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("group_order_reverser: assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define GOR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("group_order_reverser: assertion failed");

`endif

/* rtl/gor_pkg.sv */
// Shared types and constants of the group order reverser
package gor_pkg;

    localparam int DATA_W        = 32;
    localparam int CFG_W         = 5;
    localparam int MAX_GROUP_DEF = 16;
    localparam int MAX_GROUP_HI  = 64;
    localparam int CNT_MAX_W     = $clog2(MAX_GROUP_HI + 1);
    localparam int ADDR_MAX_W    = $clog2(MAX_GROUP_HI) + 1;

    localparam logic [CFG_W-1:0] GROUP_SIZE_RST = CFG_W'(1);

    typedef struct packed {
        logic signed [DATA_W-1:0] item_value;
        logic                     list_end;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_value;
        logic                     run_last;
        logic                     list_last;
    } out_item_t;

    typedef struct packed {
        logic                 bank;
        logic [CNT_MAX_W-1:0] cnt;
        logic                 rev;
        logic                 lend;
    } cmd_t;

    typedef struct packed {
        logic                  en;
        logic [ADDR_MAX_W-1:0] addr;
        logic [DATA_W-1:0]     data;
    } mem_wr_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } done_t;

endpackage

/* rtl/gor_front.sv */
// Front end: accepts items, fills the buffer banks and issues drain commands
module gor_front
    import gor_pkg::*;
#(
    parameter int MAX_GROUP = MAX_GROUP_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_item,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output cmd_t             cmd,
    output mem_wr_t          wr,
    input  done_t            done
);

    localparam int CNT_W = $clog2(MAX_GROUP + 1);
    localparam int IDX_W = $clog2(MAX_GROUP);

    logic [CFG_W-1:0] group_size_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             bank_reg;
    logic             bank_next;
    logic [1:0]       busy_reg;
    logic [1:0]       busy_next;

    logic [CNT_W-1:0] g_eff;
    logic [CNT_W-1:0] n;
    logic             accept;
    logic             full;
    logic             flush;

    always_comb
    begin
        if (int'(group_size_reg) > MAX_GROUP)
        begin
            g_eff = CNT_W'(MAX_GROUP);
        end
        else if (group_size_reg <= CFG_W'(1))
        begin
            g_eff = CNT_W'(1);
        end
        else
        begin
            g_eff = CNT_W'(group_size_reg);
        end
    end

    assign n        = fill_reg + CNT_W'(1);
    assign full     = (n >= g_eff);
    assign flush    = full || in_item.list_end;
    assign in_ready = !busy_reg[bank_reg] && cmd_ready;
    assign accept   = in_valid && in_ready;

    assign wr.en   = accept;
    assign wr.addr = ADDR_MAX_W'({bank_reg, fill_reg[IDX_W-1:0]});
    assign wr.data = in_item.item_value;

    assign cmd_valid = accept && flush;
    assign cmd.bank  = bank_reg;
    assign cmd.cnt   = CNT_MAX_W'(n);
    assign cmd.rev   = full;
    assign cmd.lend  = in_item.list_end;

    always_comb
    begin
        fill_next = fill_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        if (done.valid)
        begin
            busy_next[done.bank] = 1'b0;
        end
        if (accept)
        begin
            if (flush)
            begin
                fill_next           = '0;
                bank_next           = !bank_reg;
                busy_next[bank_reg] = 1'b1;
            end
            else
            begin
                fill_next = n;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= GROUP_SIZE_RST;
            fill_reg       <= '0;
            bank_reg       <= 1'b0;
            busy_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                group_size_reg <= cfg_wr_data;
            end
            fill_reg <= fill_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
        end
    end

endmodule

/* rtl/gor_fifo.sv */
// Two-entry command queue between front and back end
module gor_fifo
    import gor_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/gor_back.sv */
// Back end: holds the two buffer banks and drains groups in the commanded order
`include "group_order_reverser_macros.svh"

module gor_back
    import gor_pkg::*;
#(
    parameter int MAX_GROUP = MAX_GROUP_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    input  mem_wr_t   wr,
    output done_t     done,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int CNT_W  = $clog2(MAX_GROUP + 1);
    localparam int IDX_W  = $clog2(MAX_GROUP);
    localparam int ADDR_W = IDX_W + 1;
    localparam int DEPTH  = 2 ** ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    logic              act_valid_reg;
    logic              act_valid_next;
    cmd_t              act_reg;
    logic [CNT_W-1:0]  step_reg;
    logic [CNT_W-1:0]  step_next;
    logic [DATA_W-1:0] rdata_reg;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_run_last_reg;
    logic              s1_list_last_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_item_reg;

    logic [CNT_W-1:0]  act_cnt;
    logic [CNT_W-1:0]  rd_idx;
    logic [ADDR_W-1:0] rd_addr;
    logic              last;
    logic              issue;
    logic              s1_adv;
    logic              load;

    assign act_cnt = act_reg.cnt[CNT_W-1:0];
    assign last    = (step_reg == act_cnt - CNT_W'(1));
    assign rd_idx  = act_reg.rev ? (act_cnt - CNT_W'(1) - step_reg) : step_reg;
    assign rd_addr = {act_reg.bank, rd_idx[IDX_W-1:0]};

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign issue     = act_valid_reg && (!s1_valid_reg || s1_adv);
    assign cmd_ready = !act_valid_reg || (issue && last);
    assign load      = cmd_valid && cmd_ready;

    assign done.valid = issue && last;
    assign done.bank  = act_reg.bank;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        act_valid_next = act_valid_reg;
        step_next      = step_reg;
        if (load)
        begin
            act_valid_next = 1'b1;
            step_next      = '0;
        end
        else if (issue && last)
        begin
            act_valid_next = 1'b0;
        end
        else if (issue)
        begin
            step_next = step_reg + CNT_W'(1);
        end

        if (issue)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[ADDR_W-1:0]] <= wr.data;
        end
        if (issue)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            act_reg <= cmd;
        end
        if (issue)
        begin
            s1_run_last_reg  <= last;
            s1_list_last_reg <= last && act_reg.lend;
        end
        if (s1_adv)
        begin
            out_item_reg.out_value <= rdata_reg;
            out_item_reg.run_last  <= s1_run_last_reg;
            out_item_reg.list_last <= s1_list_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_valid_reg <= 1'b0;
            step_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            act_valid_reg <= act_valid_next;
            step_reg      <= step_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `GOR_ASSERT_NOW(a_act_cnt_nonzero, act_valid_reg, act_cnt != '0)
    `GOR_ASSERT_NEXT(a_step_advance, issue && !last,
        act_valid_reg && step_reg == $past(step_reg) + CNT_W'(1))
    `GOR_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_adv, s1_valid_reg && $stable(rdata_reg))
    `GOR_ASSERT_NOW(a_cmd_other_bank, cmd_valid && act_valid_reg, cmd.bank != act_reg.bank)

endmodule

/* rtl/group_order_reverser.sv */
// Top level of the group order reverser
//
//  port group   direction  handshake            payload
//  in_*         in         in_valid/in_ready    in_item (item_value, list_end)
//  out_*        out        out_valid/out_ready  out_item (out_value, run_last, list_last)
//  cfg_*        in         cfg_wr_en            cfg_wr_data (group_size)
//
// Results leave at up to one per cycle while out_ready is high; a group reaches the output
// via the command queue, active command register, registered buffer read and output stage.
// Two buffer banks alternate, so one group fills while the other drains; in pass-through
// the single read port and the bank release hold the input until the next bank has drained.
// Reset clears valid flags, counters, pointers and group size; buffer and command data stay.
// Either side may stall freely; the input stalls only while both banks are in use.
module group_order_reverser
    import gor_pkg::*;
#(
    parameter int MAX_GROUP = MAX_GROUP_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_item
);

    logic    fr_cmd_valid;
    logic    fr_cmd_ready;
    cmd_t    fr_cmd;
    logic    bk_cmd_valid;
    logic    bk_cmd_ready;
    cmd_t    bk_cmd;
    mem_wr_t wr;
    done_t   done;

    gor_front #(
        .MAX_GROUP (MAX_GROUP)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .cmd_valid   (fr_cmd_valid),
        .cmd_ready   (fr_cmd_ready),
        .cmd         (fr_cmd),
        .wr          (wr),
        .done        (done)
    );

    gor_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_cmd_valid),
        .push_ready (fr_cmd_ready),
        .push_cmd   (fr_cmd),
        .pop_valid  (bk_cmd_valid),
        .pop_ready  (bk_cmd_ready),
        .pop_cmd    (bk_cmd)
    );

    gor_back #(
        .MAX_GROUP (MAX_GROUP)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (bk_cmd_valid),
        .cmd_ready (bk_cmd_ready),
        .cmd       (bk_cmd),
        .wr        (wr),
        .done      (done),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

/* tb/group_order_reverser_checker.sv */
// Checker of the group order reverser: mirrors the reordering and compares every result item
module group_order_reverser_checker
    import gor_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    input  logic             in_ready,
    input  in_item_t         in_item,
    input  logic             out_valid,
    input  logic             out_ready,
    input  out_item_t        out_item,
    output int               mismatches,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [DATA_W-1:0] held_vals [MAX_GROUP_DEF];
    int                held_cnt;
    logic [CFG_W-1:0]  grp_size;
    out_item_t         reordered_q [$];

    function automatic int group_len(logic [CFG_W-1:0] size);
        if (size <= 1)
            return 1;
        if (size > MAX_GROUP_DEF)
            return MAX_GROUP_DEF;
        return int'(size);
    endfunction

    // store one value, then emit a full group newest first or a list tail in arrival order
    function void reorder_item(in_item_t it);
        int        g;
        int        n;
        out_item_t r;
        g = group_len(grp_size);
        if (held_cnt >= MAX_GROUP_DEF)
            held_cnt = 0;
        held_vals[held_cnt] = it.item_value;
        held_cnt++;
        n = held_cnt;
        if (n >= g)
        begin
            for (int i = 0; i < n; i++)
            begin
                r.out_value = held_vals[n - 1 - i];
                r.run_last  = (i == n - 1);
                r.list_last = (i == n - 1) && it.list_end;
                reordered_q.push_back(r);
            end
            held_cnt = 0;
        end
        else if (it.list_end)
        begin
            for (int i = 0; i < n; i++)
            begin
                r.out_value = held_vals[i];
                r.run_last  = (i == n - 1);
                r.list_last = (i == n - 1);
                reordered_q.push_back(r);
            end
            held_cnt = 0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            held_cnt    = 0;
            grp_size    = GROUP_SIZE_RST;
            reordered_q.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_wr_en)
                grp_size = cfg_wr_data;
            if (in_valid && in_ready)
                reorder_item(in_item);
            if (out_valid && out_ready)
            begin
                if (reordered_q.size() == 0)
                begin
                    $error("unexpected result item: out_value %0d", out_item.out_value);
                    mismatches++;
                end
                else
                begin
                    want = reordered_q.pop_front();
                    if (out_item.out_value !== want.out_value)
                    begin
                        $error("out_value: expected %0d, actual %0d",
                               want.out_value, out_item.out_value);
                        mismatches++;
                    end
                    if (out_item.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %0b, actual %0b",
                               want.run_last, out_item.run_last);
                        mismatches++;
                    end
                    if (out_item.list_last !== want.list_last)
                    begin
                        $error("list_last: expected %0b, actual %0b",
                               want.list_last, out_item.list_last);
                        mismatches++;
                    end
                end
            end
            outstanding = reordered_q.size();
        end
    end

endmodule

/* tb/tb_group_order_reverser.sv */
// Testbench top of the group order reverser: stimulus, idling, pressure and verdict
module tb_group_order_reverser;
    import gor_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PHASE_ITEMS = 26;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             in_valid    = 1'b0;
    logic             in_ready;
    in_item_t         in_item     = '0;
    logic             out_valid;
    logic             out_ready   = 1'b0;
    out_item_t        out_item;
    int               mismatches;
    int               outstanding;

    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    logic             hold_req    = 1'b0;
    logic             hold_taken  = 1'b0;
    int               hold_left   = 0;
    int unsigned      cycle_cnt   = 0;

    logic [CFG_W-1:0] phase_size [8] = '{5'd2, 5'd16, 5'd31, 5'd5, 5'd0, 5'd3, 5'd4, 5'd17};

    group_order_reverser i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

    group_order_reverser_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // hold off once for a long stretch on request, otherwise stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_taken)
        begin
            out_ready  <= 1'b0;
            hold_left  <= 80;
            hold_taken <= 1'b1;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'h0000_0000;
            3:       v = 32'hFFFF_FFFF;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_item(input logic [DATA_W-1:0] v, input logic last);
        in_item_t it;
        logic     taken;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        it.item_value = v;
        it.list_end   = last;
        in_valid <= 1'b1;
        in_item  <= it;
        forever
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
            if (taken)
                break;
        end
    endtask

    // drop valid, wait for every result, then let a held item settle
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_group_size(input logic [CFG_W-1:0] size);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                tx_idle_pct =  16;
                rx_idle_pct <= 77;
            end
            1:
            begin
                tx_idle_pct =  77;
                rx_idle_pct <= 16;
            end
            default:
            begin
                tx_idle_pct =  0;
                rx_idle_pct <= 0;
            end
        endcase
    endtask

    initial
    begin
        int g;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(0);
        @(posedge clk);

        // pass through at reset size
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b1);
        send_item(32'h0000_0000, 1'b0);
        settle();

        // full group closed by list end, then a short list tail
        write_group_size(5'd4);
        send_item(32'h0000_0001, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b1);
        send_item(32'h1234_5678, 1'b0);
        send_item(32'hDEAD_BEEF, 1'b1);
        settle();

        // lower the size while a group is partly filled
        write_group_size(5'd8);
        for (int i = 0; i < 5; i++)
            send_item(pick_value(), 1'b0);
        settle();
        write_group_size(5'd3);
        send_item(pick_value(), 1'b0);
        settle();

        write_group_size(5'd0);
        send_item(32'hFFFF_FFFF, 1'b1);
        send_item(pick_value(), 1'b0);
        settle();

        for (int p = 0; p < 8; p++)
        begin
            set_idling(p / 3);
            write_group_size(phase_size[p]);
            g = (phase_size[p] <= 1) ? 1 :
                (phase_size[p] > MAX_GROUP_DEF) ? MAX_GROUP_DEF : int'(phase_size[p]);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 6 && k == 4)
                    hold_req <= 1'b1;
                send_item(pick_value(), ($urandom_range(0, 3 * g) == 0));
            end
            settle();
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/gor_pkg.sv
rtl/gor_front.sv
rtl/gor_fifo.sv
rtl/gor_back.sv
rtl/group_order_reverser.sv
tb/group_order_reverser_checker.sv
tb/tb_group_order_reverser.sv
